>>> rtl/core/hlsr_pkg.sv
// shared types, constants and float helpers for the highland scattering angle core
package hlsr_pkg;

	typedef logic signed [9:0] exp_t;

	// 32-bit mantissa with top bit set, value = m * 2^e
	typedef struct packed {
		logic [31:0] m;
		exp_t        e;
	} fl_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_ZERO_T = 2'd1,
		ST_BETA   = 2'd2,
		ST_SAT    = 2'd3
	} status_t;

	typedef struct packed {
		logic    vld;
		logic    zero_out;
		status_t st;
		logic    big;
	} ctrl_t;

	localparam logic [31:0] K_HIGHLAND = 32'd3650722202;
	localparam logic [26:0] K_LN       = 27'd113127690;
	localparam logic [31:0] ONE_Q30    = 32'd1073741824;

	localparam logic CFG_MASS   = 1'b0;
	localparam logic CFG_CHARGE = 1'b1;

	localparam int SQRT_STEPS = 32;
	localparam int LOG_STEPS  = 30;
	localparam int DIV_STEPS  = 33;
	localparam int LAT_TOTAL  = 75;

	function automatic fl_t fl_mul(fl_t a, fl_t b);
		logic [63:0] p;
		fl_t         r;
		p   = {32'b0, a.m} * {32'b0, b.m};
		r.m = p[63] ? p[63:32] : p[62:31];
		r.e = a.e + b.e + exp_t'(31) + exp_t'({9'b0, p[63]});
		return r;
	endfunction

	function automatic exp_t lead_exp(logic [5:0] l);
		return exp_t'({4'b0, l});
	endfunction

endpackage

>>> rtl/core/highland_scatter_rms_angle_core.sv
// highland rms scattering angle core, fully pipelined
// throughput: one request per cycle while busy is low; latency is set by the 32-step energy
// square root and the 33-step divider in series, the 30-step squaring log unit runs alongside
// the square roots
// reset: asynchronous, clears config to mass 8 and charge 1, busy high for one cycle after
module highland_scatter_rms_angle_core import hlsr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] thickness_rl,
	input  logic [31:0] momentum_in,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [27:0] cfg_wdata,
	output logic        done,
	output logic [31:0] angle_rad,
	output logic [1:0]  status
);
	logic [27:0] mass_q;
	logic [3:0]  charge_q;
	logic        busy_q;
	fl_t         v1_q;

	ctrl_t ctrl_in;
	ctrl_t ctrl_s [1:LAT_TOTAL-1];

	logic [31:0] t_s1;
	logic [63:0] p2_s1;
	logic [55:0] m2_s1;
	logic [63:0] rade_s2;
	logic [63:0] p2_s2;

	logic [31:0] sroot_s33;
	logic [31:0] eroot_s34;
	logic [31:0] sm_s35;
	logic [4:0]  sl_s35;
	logic [31:0] em_s36;
	logic [4:0]  el_s36;
	logic [31:0] tm_s3;
	logic [4:0]  tl_s3;
	logic [31:0] corr_s36;
	logic [31:0] cm_s38;
	logic [4:0]  cl_s38;
	logic [31:0] pm_s4;
	logic [5:0]  pl_s4;

	fl_t z_fl, k_fl, s_fl, e_fl, c_fl, p_fl;
	logic [1:0] zlead;

	fl_t v2_s36, v2_s37, v2_s38;
	fl_t e_s37, e_s38, e_s39;
	fl_t v3_s39, v4_s40;
	fl_t pd_s [5:40];
	exp_t ediff_c;
	exp_t ed_s [41:73];
	logic [32:0] q_s73;
	logic [31:0] m_s74;
	exp_t        sh_s74;

	exp_t        nsh;
	logic [31:0] theta_c;
	status_t     status_c;
	logic        done_q;
	logic [31:0] theta_q;
	status_t     status_q;

	// config and busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q   <= 28'd8;
			charge_q <= 4'd1;
			busy_q   <= 1'b1;
		end else begin
			busy_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_idx)
					CFG_MASS:   mass_q   <= cfg_wdata;
					CFG_CHARGE: charge_q <= cfg_wdata[3:0];
					default:    ;
				endcase
			end
		end
	end

	// constant part of the product: 217.6 * z
	always_comb begin
		if (charge_q[3]) zlead = 2'd3;
		else if (charge_q[2]) zlead = 2'd2;
		else if (charge_q[1]) zlead = 2'd1;
		else zlead = 2'd0;
		z_fl.m = {charge_q << (2'd3 - zlead), 28'b0};
		z_fl.e = exp_t'({8'b0, zlead}) - exp_t'(31);
		k_fl.m = K_HIGHLAND;
		k_fl.e = exp_t'(-24);
	end

	always_ff @(posedge clk) begin
		v1_q <= fl_mul(k_fl, z_fl);
	end

	// special cases decided on entry
	always_comb begin
		ctrl_in.vld      = start && !busy_q;
		ctrl_in.big      = momentum_in[31];
		ctrl_in.zero_out = 1'b1;
		ctrl_in.st       = ST_OK;
		if (thickness_rl == '0) begin
			ctrl_in.st = ST_ZERO_T;
		end else if (mass_q == '0 || momentum_in == '0) begin
			ctrl_in.st = ST_BETA;
		end else if (charge_q == '0) begin
			ctrl_in.st = ST_OK;
		end else begin
			ctrl_in.zero_out = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k < LAT_TOTAL; k++) begin
				ctrl_s[k] <= '0;
			end
		end else begin
			ctrl_s[1] <= ctrl_in;
			for (int k = 2; k < LAT_TOTAL; k++) begin
				ctrl_s[k] <= ctrl_s[k-1];
			end
		end
	end

	// energy radicand, quartered when momentum uses the top bit
	always_ff @(posedge clk) begin
		t_s1    <= thickness_rl;
		p2_s1   <= {32'b0, momentum_in} * {32'b0, momentum_in};
		m2_s1   <= {28'b0, mass_q} * {28'b0, mass_q};
		rade_s2 <= ctrl_s[1].big ? ({2'b0, p2_s1[63:2]} + {10'b0, m2_s1[55:2]})
		                         : (p2_s1 + {8'b0, m2_s1});
		p2_s2   <= p2_s1;
	end

	hlsr_isqrt u_sqrt_t (.clk(clk), .radicand({t_s1, 32'b0}), .root(sroot_s33));
	hlsr_isqrt u_sqrt_e (.clk(clk), .radicand(rade_s2), .root(eroot_s34));

	hlsr_norm #(.W(32)) u_norm_s (.clk(clk), .x(sroot_s33), .m(sm_s35), .lead(sl_s35));
	hlsr_norm #(.W(32)) u_norm_e (.clk(clk), .x(eroot_s34), .m(em_s36), .lead(el_s36));
	hlsr_norm #(.W(32)) u_norm_t (.clk(clk), .x(t_s1), .m(tm_s3), .lead(tl_s3));
	hlsr_norm #(.W(32)) u_norm_c (.clk(clk), .x(corr_s36), .m(cm_s38), .lead(cl_s38));
	hlsr_norm #(.W(64)) u_norm_p (.clk(clk), .x(p2_s2), .m(pm_s4), .lead(pl_s4));

	hlsr_log u_log (.clk(clk), .x(tm_s3), .lead(tl_s3), .corr(corr_s36));

	always_comb begin
		s_fl.m = sm_s35;
		s_fl.e = lead_exp({1'b0, sl_s35}) - exp_t'(59);
		e_fl.m = em_s36;
		e_fl.e = lead_exp({1'b0, el_s36}) + exp_t'({9'b0, ctrl_s[36].big}) - exp_t'(31);
		c_fl.m = cm_s38;
		c_fl.e = lead_exp({1'b0, cl_s38}) - exp_t'(61);
		p_fl.m = pm_s4;
		p_fl.e = lead_exp(pl_s4) - exp_t'(31);
	end

	// product chain in the order z, sqrt(t), correction, energy
	always_ff @(posedge clk) begin
		v2_s36 <= fl_mul(v1_q, s_fl);
		v2_s37 <= v2_s36;
		v2_s38 <= v2_s37;
		e_s37  <= e_fl;
		e_s38  <= e_s37;
		e_s39  <= e_s38;
		v3_s39 <= fl_mul(v2_s38, c_fl);
		v4_s40 <= fl_mul(v3_s39, e_s39);
		pd_s[5] <= p_fl;
		for (int k = 6; k <= 40; k++) begin
			pd_s[k] <= pd_s[k-1];
		end
		ed_s[41] <= ediff_c;
		for (int k = 42; k <= 73; k++) begin
			ed_s[k] <= ed_s[k-1];
		end
	end

	assign ediff_c = v4_s40.e - pd_s[40].e - exp_t'(32);

	hlsr_div u_div (.clk(clk), .num(v4_s40.m), .den(pd_s[40].m), .quo(q_s73));

	always_ff @(posedge clk) begin
		m_s74  <= q_s73[32] ? q_s73[32:1] : q_s73[31:0];
		sh_s74 <= ed_s[73] + exp_t'({9'b0, q_s73[32]}) + exp_t'(28);
	end

	// fixed-point conversion with saturation
	always_comb begin
		nsh      = -sh_s74;
		theta_c  = '0;
		status_c = ST_OK;
		if (ctrl_s[74].zero_out) begin
			status_c = ctrl_s[74].st;
		end else if (sh_s74 > exp_t'(0)) begin
			theta_c  = '1;
			status_c = ST_SAT;
		end else if (sh_s74 == exp_t'(0)) begin
			theta_c = m_s74;
		end else if (sh_s74 > exp_t'(-32)) begin
			theta_c = m_s74 >> nsh[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl_s[74].vld;
		end
	end

	always_ff @(posedge clk) begin
		theta_q  <= theta_c;
		status_q <= status_c;
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign angle_rad = theta_q;
	assign status    = status_q;
endmodule

>>> rtl/core/hlsr_norm.sv
// two-stage normalizer: leading-one search, then left alignment to a 32-bit mantissa
module hlsr_norm #(
	parameter int W = 32
) (
	input  logic                 clk,
	input  logic [W-1:0]         x,
	output logic [31:0]          m,
	output logic [$clog2(W)-1:0] lead
);
	localparam int LW = $clog2(W);

	logic [LW-1:0]  lead_c;
	logic [W-1:0]   x_s1;
	logic [LW-1:0]  lead_s1;
	logic [LW-1:0]  amt;
	logic [W+31:0]  shifted;
	logic [31:0]    m_s2;
	logic [LW-1:0]  lead_s2;

	always_comb begin
		lead_c = '0;
		for (int i = 0; i < W; i++) begin
			if (x[i]) begin
				lead_c = LW'(i);
			end
		end
	end

	assign amt     = LW'(W - 1) - lead_s1;
	assign shifted = {x_s1, 32'b0} << amt;

	always_ff @(posedge clk) begin
		x_s1    <= x;
		lead_s1 <= lead_c;
		m_s2    <= shifted[W+31 -: 32];
		lead_s2 <= lead_s1;
	end

	assign m    = m_s2;
	assign lead = lead_s2;
endmodule

>>> rtl/core/hlsr_isqrt.sv
// pipelined integer square root, 64-bit radicand, one root bit per stage
module hlsr_isqrt import hlsr_pkg::*; (
	input  logic        clk,
	input  logic [63:0] radicand,
	output logic [31:0] root
);
	logic [63:0] rad_s  [1:SQRT_STEPS-1];
	logic [32:0] rem_s  [1:SQRT_STEPS];
	logic [31:0] root_s [1:SQRT_STEPS];

	logic [63:0] rad_c  [0:SQRT_STEPS-1];
	logic [32:0] rem_c  [0:SQRT_STEPS-1];
	logic [31:0] root_c [0:SQRT_STEPS-1];
	logic [32:0] rem_n  [0:SQRT_STEPS-1];
	logic [31:0] root_n [0:SQRT_STEPS-1];

	always_comb begin
		logic [34:0] acc;
		logic [34:0] trial;
		logic [34:0] diff;
		logic        ge;
		for (int i = 0; i < SQRT_STEPS; i++) begin
			if (i == 0) begin
				rad_c[i]  = radicand;
				rem_c[i]  = '0;
				root_c[i] = '0;
			end else begin
				rad_c[i]  = rad_s[i];
				rem_c[i]  = rem_s[i];
				root_c[i] = root_s[i];
			end
		end
		for (int i = 0; i < SQRT_STEPS; i++) begin
			acc   = {rem_c[i], rad_c[i][63:62]};
			trial = {1'b0, root_c[i], 2'b01};
			diff  = acc - trial;
			ge    = (acc >= trial);
			rem_n[i]  = ge ? diff[32:0] : acc[32:0];
			root_n[i] = {root_c[i][30:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 1; i < SQRT_STEPS; i++) begin
			rad_s[i] <= rad_c[i-1] << 2;
		end
		for (int i = 0; i < SQRT_STEPS; i++) begin
			rem_s[i+1]  <= rem_n[i];
			root_s[i+1] <= root_n[i];
		end
	end

	assign root = root_s[SQRT_STEPS];
endmodule

>>> rtl/core/hlsr_log.sv
// log correction 1 + 0.038 ln t in q2.30: squaring pipeline for log2 bits, then scale
module hlsr_log import hlsr_pkg::*; (
	input  logic        clk,
	input  logic [31:0] x,
	input  logic [4:0]  lead,
	output logic [31:0] corr
);
	logic [31:0]          sx_s [1:LOG_STEPS];
	logic [LOG_STEPS-1:0] sf_s [1:LOG_STEPS];
	logic [4:0]           sl_s [1:LOG_STEPS];

	logic [31:0]          x_c [0:LOG_STEPS-1];
	logic [LOG_STEPS-1:0] f_c [0:LOG_STEPS-1];
	logic [4:0]           l_c [0:LOG_STEPS-1];
	logic [31:0]          x_n [0:LOG_STEPS-1];
	logic [LOG_STEPS-1:0] f_n [0:LOG_STEPS-1];

	logic        neg_s31;
	logic [34:0] absq_s31;
	logic        neg_s32;
	logic [56:0] plo_s32;
	logic [31:0] phi_s32;
	logic [31:0] corr_s33;

	logic [4:0]  hi;
	logic        lneg;
	logic [34:0] absq;
	logic [61:0] mag;

	always_comb begin
		logic [63:0] p;
		for (int i = 0; i < LOG_STEPS; i++) begin
			if (i == 0) begin
				x_c[i] = x;
				f_c[i] = '0;
				l_c[i] = lead;
			end else begin
				x_c[i] = sx_s[i];
				f_c[i] = sf_s[i];
				l_c[i] = sl_s[i];
			end
		end
		for (int i = 0; i < LOG_STEPS; i++) begin
			p      = {32'b0, x_c[i]} * {32'b0, x_c[i]};
			x_n[i] = p[63] ? p[63:32] : p[62:31];
			f_n[i] = {f_c[i][LOG_STEPS-2:0], p[63]};
		end
	end

	// signed log2 offset turned into magnitude and sign
	always_comb begin
		lneg = (sl_s[LOG_STEPS] < 5'd24);
		hi   = lneg ? (5'd24 - sl_s[LOG_STEPS]) : (sl_s[LOG_STEPS] - 5'd24);
		absq = lneg ? ({hi, 30'b0} - {5'b0, sf_s[LOG_STEPS]}) : {hi, sf_s[LOG_STEPS]};
		mag  = {5'b0, plo_s32} + {phi_s32, 30'b0};
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < LOG_STEPS; i++) begin
			sx_s[i+1] <= x_n[i];
			sf_s[i+1] <= f_n[i];
			sl_s[i+1] <= l_c[i];
		end
		neg_s31  <= lneg;
		absq_s31 <= absq;
		neg_s32  <= neg_s31;
		plo_s32  <= {30'b0, K_LN} * {27'b0, absq_s31[29:0]};
		phi_s32  <= {5'b0, K_LN} * {27'b0, absq_s31[34:30]};
		corr_s33 <= neg_s32 ? (ONE_Q30 - {2'b0, mag[61:32]}) : (ONE_Q30 + {2'b0, mag[61:32]});
	end

	assign corr = corr_s33;
endmodule

>>> rtl/core/hlsr_div.sv
// pipelined restoring divider: (num << 32) / den for normalized mantissas, 33 quotient bits
module hlsr_div import hlsr_pkg::*; (
	input  logic        clk,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic [32:0] quo
);
	logic [31:0] rem_s [1:DIV_STEPS];
	logic [31:0] den_s [1:DIV_STEPS-1];
	logic [32:0] quo_s [1:DIV_STEPS];

	logic [31:0] rem_c [0:DIV_STEPS-1];
	logic [31:0] den_c [0:DIV_STEPS-1];
	logic [32:0] quo_c [0:DIV_STEPS-1];
	logic        dbit  [0:DIV_STEPS-1];
	logic [31:0] rem_n [0:DIV_STEPS-1];
	logic [32:0] quo_n [0:DIV_STEPS-1];

	always_comb begin
		logic [32:0] acc;
		logic [32:0] diff;
		logic        ge;
		for (int i = 0; i < DIV_STEPS; i++) begin
			if (i == 0) begin
				rem_c[i] = {1'b0, num[31:1]};
				den_c[i] = den;
				quo_c[i] = '0;
				dbit[i]  = num[0];
			end else begin
				rem_c[i] = rem_s[i];
				den_c[i] = den_s[i];
				quo_c[i] = quo_s[i];
				dbit[i]  = 1'b0;
			end
		end
		for (int i = 0; i < DIV_STEPS; i++) begin
			acc      = {rem_c[i], dbit[i]};
			diff     = acc - {1'b0, den_c[i]};
			ge       = (acc >= {1'b0, den_c[i]});
			rem_n[i] = ge ? diff[31:0] : acc[31:0];
			quo_n[i] = {quo_c[i][31:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 1; i < DIV_STEPS; i++) begin
			den_s[i] <= den_c[i-1];
		end
		for (int i = 0; i < DIV_STEPS; i++) begin
			rem_s[i+1] <= rem_n[i];
			quo_s[i+1] <= quo_n[i];
		end
	end

	assign quo = quo_s[DIV_STEPS];
endmodule

>>> rtl/core/hlsr_check.sv
// port-level checker for the highland scattering angle core, bound to the top level
module hlsr_check import hlsr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] thickness_rl,
	input logic [31:0] angle_rad,
	input logic [1:0]  status
);
	// every request comes back after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT_TOTAL done)
		else $error("result missing after request");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT_TOTAL))
		else $error("result without a request");

	a_zero_thick: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && thickness_rl == '0 |->
		##LAT_TOTAL (status == ST_ZERO_T && angle_rad == '0))
		else $error("zero thickness not flagged");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_SAT |-> angle_rad == '1)
		else $error("saturated result not at full scale");
endmodule

bind highland_scatter_rms_angle_core hlsr_check u_check (.*);

>>> tb/highland_scatter_rms_angle_core_tb.sv
// testbench for the highland rms scattering angle core: self-checking, random and directed requests
module highland_scatter_rms_angle_core_tb;
	import hlsr_pkg::*;

	typedef struct {
		logic [31:0] m;
		int          e;
	} num_t;

	typedef struct {
		logic [31:0] theta;
		status_t     st;
	} angle_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] thickness_rl;
	logic [31:0] momentum_in;
	logic        cfg_we;
	logic        cfg_idx;
	logic [27:0] cfg_wdata;
	logic        done;
	logic [31:0] angle_rad;
	logic [1:0]  status;

	angle_t      angle_q[$];
	logic [27:0] mass_reg;
	logic [3:0]  charge_reg;
	int          errors;
	int          n_req;
	int          n_res;
	int          n_sat;
	int          n_zero_t;
	int          n_beta;
	longint      cycles;
	bit          idle_on;

	localparam longint CYCLE_LIMIT = 400000;

	highland_scatter_rms_angle_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.thickness_rl(thickness_rl), .momentum_in(momentum_in),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.done(done), .angle_rad(angle_rad), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic num_t to_num(logic [63:0] x, int e);
		num_t r;
		while (x[63] == 1'b0) begin
			x = x << 1;
			e = e - 1;
		end
		r.m = x[63:32];
		r.e = e + 32;
		return r;
	endfunction

	function automatic num_t num_mul(num_t a, num_t b);
		logic [63:0] p;
		num_t        r;
		p = 64'(a.m) * 64'(b.m);
		if (p[63]) begin
			r.m = p[63:32];
			r.e = a.e + b.e + 32;
		end else begin
			r.m = p[62:31];
			r.e = a.e + b.e + 31;
		end
		return r;
	endfunction

	function automatic num_t num_div(num_t a, num_t b);
		logic [63:0] q;
		num_t        r;
		q = {a.m, 32'b0} / 64'(b.m);
		if (q[63:32] != 0) begin
			r.m = q[32:1];
			r.e = a.e - b.e - 31;
		end else begin
			r.m = q[31:0];
			r.e = a.e - b.e - 32;
		end
		return r;
	endfunction

	// 1 + 0.038 ln t in Q2.30
	function automatic logic [31:0] log_corr(logic [31:0] t);
		int          e;
		logic [63:0] x;
		logic [31:0] frac;
		longint      lq;
		longint      prod;
		logic [63:0] mag;
		logic [63:0] d;
		e = 31;
		frac = 0;
		while (t[e] == 1'b0) e--;
		x = 64'(t) << (31 - e);
		for (int i = 0; i < 30; i++) begin
			x = (x * x) >> 31;
			frac = frac << 1;
			if (x[63:32] != 0) begin
				frac[0] = 1'b1;
				x = x >> 1;
			end
		end
		lq = longint'(e - 24) * longint'(ONE_Q30) + longint'(frac);
		prod = longint'(K_LN) * lq;
		mag = prod < 0 ? 64'(-prod) : 64'(prod);
		d = mag >> 32;
		return prod < 0 ? 32'(ONE_Q30 - d) : 32'(ONE_Q30 + d);
	endfunction

	function automatic angle_t predict_angle(logic [31:0] t, logic [31:0] p);
		angle_t      r;
		logic [63:0] p2;
		logic [63:0] m2;
		num_t        v;
		num_t        en;
		int          sh;
		r.theta = 0;
		r.st = ST_OK;
		p2 = 64'(p) * 64'(p);
		m2 = 64'(mass_reg) * 64'(mass_reg);
		if (t == 0) begin
			r.st = ST_ZERO_T;
		end else if (mass_reg == 0 || p == 0) begin
			r.st = ST_BETA;
		end else if (charge_reg != 0) begin
			if (p[31] == 1'b0) en = to_num(int_sqrt(p2 + m2), 0);
			else en = to_num(int_sqrt((p2 >> 2) + (m2 >> 2)), 1);
			v = num_mul(to_num(64'(K_HIGHLAND), -24), to_num(64'(charge_reg), 0));
			v = num_mul(v, to_num(int_sqrt({t, 32'b0}), -28));
			v = num_mul(v, to_num(64'(log_corr(t)), -30));
			v = num_mul(v, en);
			v = num_div(v, to_num(p2, 0));
			sh = v.e + 28;
			if (sh > 0) begin
				r.theta = 32'hFFFF_FFFF;
				r.st = ST_SAT;
			end else if (sh == 0) begin
				r.theta = v.m;
			end else if (sh > -32) begin
				r.theta = v.m >> (-sh);
			end
		end
		return r;
	endfunction

	// requests and results are both seen at the edge, before any update lands
	always @(posedge clk) begin
		angle_t exp_a;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at %0t", $time);
			$display("CHECK FAILED");
			$finish;
		end
		if (arst_n && start && !busy) begin
			angle_q.push_back(predict_angle(thickness_rl, momentum_in));
			n_req++;
		end
		if (arst_n && done) begin
			if (angle_q.size() == 0) begin
				$display("%0t: unexpected result theta=%h status=%0d", $time, angle_rad, status);
				errors++;
			end else begin
				exp_a = angle_q.pop_front();
				n_res++;
				if (exp_a.st == ST_SAT) n_sat++;
				if (exp_a.st == ST_ZERO_T) n_zero_t++;
				if (exp_a.st == ST_BETA) n_beta++;
				if (angle_rad !== exp_a.theta) begin
					$display("%0t: theta mismatch expected %h actual %h", $time,
						exp_a.theta, angle_rad);
					errors++;
				end
				if (status !== exp_a.st) begin
					$display("%0t: status mismatch expected %0d actual %0d", $time,
						exp_a.st, status);
					errors++;
				end
			end
		end
	end

	task automatic send_req(logic [31:0] t, logic [31:0] p);
		if (idle_on && $urandom_range(99) < 35) begin
			start <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		thickness_rl <= t;
		momentum_in <= p;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (angle_q.size() != 0) @(posedge clk);
		repeat (LAT_TOTAL + 5) @(posedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [27:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MASS) mass_reg = val;
		else charge_reg = val[3:0];
	endtask

	function automatic logic [31:0] rand_spread();
		return $urandom >> $urandom_range(31, 0);
	endfunction

	task automatic test_directed();
		send_req(32'd0, 32'd1000);
		send_req(32'd0, 32'hFFFF_FFFF);
		send_req(32'h0100_0000, 32'd0);
		send_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_req(32'hFFFF_FFFF, 32'd1);
		send_req(32'd1, 32'hFFFF_FFFF);
		send_req(32'd1, 32'd1);
		send_req(32'h0100_0000, 32'h8000_0000);
		send_req(32'h0100_0000, 32'h7FFF_FFFF);
		send_req(32'h0100_0000, 32'd16000);
		send_req(32'h0019_999A, 32'd1600);
		send_req(32'h8000_0000, 32'd160);
	endtask

	task automatic test_massless();
		write_cfg(CFG_MASS, 28'd0);
		send_req(32'h0100_0000, 32'd16000);
		send_req(32'd0, 32'd16000);
		send_req(32'hFFFF_FFFF, 32'd0);
	endtask

	task automatic test_charge();
		write_cfg(CFG_MASS, 28'hFFF_FFFF);
		write_cfg(CFG_CHARGE, 28'hABC_DEF0);
		send_req(32'h0100_0000, 32'd16000);
		send_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		write_cfg(CFG_CHARGE, 28'h000_000F);
		send_req(32'h0100_0000, 32'd16000);
		send_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_req(32'h0000_0100, 32'd2);
	endtask

	task automatic random_batch(int n);
		logic [31:0] t;
		logic [31:0] p;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: begin t = $urandom; p = $urandom; end
				1: begin t = (i % 13 == 0) ? 32'd0 : $urandom; p = rand_spread(); end
				default: begin t = rand_spread(); p = rand_spread(); end
			endcase
			if ($urandom_range(49) == 0) p = 0;
			send_req(t, p);
		end
	endtask

	task automatic test_random();
		logic [27:0] masses[5];
		logic [3:0]  charges[4];
		masses = '{28'd1, 28'd8, 28'd15008, 28'hFFF_FFFF, 28'd1672};
		charges = '{4'd1, 4'd2, 4'd15, 4'd0};
		for (int k = 0; k < 5; k++) begin
			write_cfg(CFG_MASS, masses[k] == 0 ? 28'd1 : masses[k]);
			write_cfg(CFG_CHARGE, {24'(k * 77), charges[k % 4]});
			random_batch(60);
			// hold until the pipeline is empty mid-stream
			if (k == 2) drain();
			random_batch(30);
		end
		write_cfg(CFG_MASS, 28'($urandom));
		write_cfg(CFG_CHARGE, 28'($urandom_range(15, 1)));
		idle_on = 0;
		random_batch(100);
		idle_on = 1;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		thickness_rl = 0;
		momentum_in = 0;
		cfg_we = 1'b0;
		cfg_idx = CFG_MASS;
		cfg_wdata = 0;
		mass_reg = 28'd8;
		charge_reg = 4'd1;
		errors = 0;
		n_req = 0;
		n_res = 0;
		n_sat = 0;
		n_zero_t = 0;
		n_beta = 0;
		cycles = 0;
		idle_on = 1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_massless();
		test_charge();
		test_random();
		drain();
		$display("%0d requests, %0d results checked", n_req, n_res);
		$display("saturated %0d, zero thickness %0d, beta out of range %0d",
			n_sat, n_zero_t, n_beta);
		if (errors == 0 && angle_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/hlsr_pkg.sv
rtl/core/hlsr_norm.sv
rtl/core/hlsr_isqrt.sv
rtl/core/hlsr_log.sv
rtl/core/hlsr_div.sv
rtl/core/highland_scatter_rms_angle_core.sv
rtl/core/hlsr_check.sv
tb/highland_scatter_rms_angle_core_tb.sv
